// ===== sv/dltr_pkg.sv =====
package dltr_pkg;

   // Literal limits and field widths
   localparam int MaxDecimalDigits = 18;
   localparam int NumW = 63;
   localparam int DenW = 60;
   localparam int CharW = 8;
   localparam int UpcW = 5;
   localparam int Pow5W = 42;

   localparam logic [NumW-1:0] NumMax = {NumW{1'b1}};
   // Largest value that can still be multiplied by ten without passing NumMax
   localparam logic [63:0] NumMaxDiv10 = 64'd922337203685477580;
   // n * inverse(5) mod 2^64 stays at or below this exactly when 5 divides n
   localparam logic [63:0] Div5Limit = 64'h3333333333333333;

   // Character codes
   localparam logic [CharW-1:0] CharZero  = 8'h30;
   localparam logic [CharW-1:0] CharNine  = 8'h39;
   localparam logic [CharW-1:0] CharDot   = 8'h2E;
   localparam logic [CharW-1:0] CharLowE  = 8'h65;
   localparam logic [CharW-1:0] CharUpE   = 8'h45;
   localparam logic [CharW-1:0] CharPlus  = 8'h2B;
   localparam logic [CharW-1:0] CharMinus = 8'h2D;

   typedef enum logic [1:0] {
      StOk         = 2'd0,
      StNoExpDigit = 2'd1,
      StOverflow   = 2'd2,
      StBadChar    = 2'd3
   } status_type;

   // Summary of one finished literal, handed from the lexer to the datapath
   typedef struct packed {
      logic [NumW-1:0]   mantissa;
      logic signed [9:0] net;
      status_type        status;
   } lit_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OpNop,
      OpSetOvf,
      OpSetK,
      OpHalve,
      OpMul3,
      OpAddSh4,
      OpAddSh8,
      OpAddSh16,
      OpAddSh32,
      OpQuot,
      OpTakeQ,
      OpMul10,
      OpSat,
      OpEmit
   } dp_op_type;

   // Jump conditions
   typedef enum logic [3:0] {
      CondNone,
      CondAlways,
      CondErr,
      CondZero,
      CondNetPos,
      CondSmallNeg,
      CondTwoStop,
      CondK5Zero,
      CondNotDiv5,
      CondCntZero,
      CondNumBig,
      CondOutBusy
   } cond_type;

   typedef logic [UpcW-1:0] upc_type;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      upc_type   target;
      logic      fin;
   } uword_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic err;
      logic zero;
      logic net_pos;
      logic small_neg;
      logic two_stop;
      logic k5_zero;
      logic not_div5;
      logic cnt_zero;
      logic num_big;
   } flags_type;

   // Program labels
   localparam upc_type StepNeg  = 5'd5;
   localparam upc_type StepTwo  = 5'd6;
   localparam upc_type StepFive = 5'd8;
   localparam upc_type StepPos  = 5'd17;
   localparam upc_type StepSat  = 5'd20;
   localparam upc_type StepEmit = 5'd21;

   // Reduction program: one control word per step
   function automatic uword_type ucode(upc_type addr);
      uword_type w;
      w = '{op: OpNop, cond: CondNone, target: '0, fin: 1'b1};
      unique case (addr)
         5'd0:  w = '{op: OpNop,     cond: CondErr,      target: StepEmit, fin: 1'b0};
         5'd1:  w = '{op: OpNop,     cond: CondZero,     target: StepEmit, fin: 1'b0};
         5'd2:  w = '{op: OpNop,     cond: CondNetPos,   target: StepPos,  fin: 1'b0};
         5'd3:  w = '{op: OpNop,     cond: CondSmallNeg, target: StepNeg,  fin: 1'b0};
         5'd4:  w = '{op: OpSetOvf,  cond: CondAlways,   target: StepEmit, fin: 1'b0};
         5'd5:  w = '{op: OpSetK,    cond: CondNone,     target: '0,       fin: 1'b0};
         5'd6:  w = '{op: OpNop,     cond: CondTwoStop,  target: StepFive, fin: 1'b0};
         5'd7:  w = '{op: OpHalve,   cond: CondAlways,   target: StepTwo,  fin: 1'b0};
         5'd8:  w = '{op: OpNop,     cond: CondK5Zero,   target: StepEmit, fin: 1'b0};
         5'd9:  w = '{op: OpMul3,    cond: CondNone,     target: '0,       fin: 1'b0};
         5'd10: w = '{op: OpAddSh4,  cond: CondNone,     target: '0,       fin: 1'b0};
         5'd11: w = '{op: OpAddSh8,  cond: CondNone,     target: '0,       fin: 1'b0};
         5'd12: w = '{op: OpAddSh16, cond: CondNone,     target: '0,       fin: 1'b0};
         5'd13: w = '{op: OpAddSh32, cond: CondNone,     target: '0,       fin: 1'b0};
         5'd14: w = '{op: OpQuot,    cond: CondNone,     target: '0,       fin: 1'b0};
         5'd15: w = '{op: OpNop,     cond: CondNotDiv5,  target: StepEmit, fin: 1'b0};
         5'd16: w = '{op: OpTakeQ,   cond: CondAlways,   target: StepFive, fin: 1'b0};
         5'd17: w = '{op: OpNop,     cond: CondCntZero,  target: StepEmit, fin: 1'b0};
         5'd18: w = '{op: OpNop,     cond: CondNumBig,   target: StepSat,  fin: 1'b0};
         5'd19: w = '{op: OpMul10,   cond: CondAlways,   target: StepPos,  fin: 1'b0};
         5'd20: w = '{op: OpSat,     cond: CondAlways,   target: StepEmit, fin: 1'b0};
         5'd21: w = '{op: OpEmit,    cond: CondOutBusy,  target: StepEmit, fin: 1'b1};
         default: w = '{op: OpNop,   cond: CondNone,     target: '0,       fin: 1'b1};
      endcase
      return w;
   endfunction

   // Powers of five up to the largest denominator exponent
   function automatic logic [Pow5W-1:0] pow5(logic [4:0] k);
      logic [Pow5W-1:0] p;
      p = '0;
      case (k)
         5'd0:  p = 42'd1;
         5'd1:  p = 42'd5;
         5'd2:  p = 42'd25;
         5'd3:  p = 42'd125;
         5'd4:  p = 42'd625;
         5'd5:  p = 42'd3125;
         5'd6:  p = 42'd15625;
         5'd7:  p = 42'd78125;
         5'd8:  p = 42'd390625;
         5'd9:  p = 42'd1953125;
         5'd10: p = 42'd9765625;
         5'd11: p = 42'd48828125;
         5'd12: p = 42'd244140625;
         5'd13: p = 42'd1220703125;
         5'd14: p = 42'd6103515625;
         5'd15: p = 42'd30517578125;
         5'd16: p = 42'd152587890625;
         5'd17: p = 42'd762939453125;
         5'd18: p = 42'd3814697265625;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

// ===== sv/decimal_literal_to_rational.sv =====
// Converts one unsigned decimal literal, sent one character per item with the
// final character marked, into a reduced fraction numerator/denominator with an
// is-whole mark and a status code. Characters before the last are taken one
// per cycle while the sequencer is idle. The final character hands the literal
// to a microcoded reduction sequencer and the input stalls until its result is
// written to the output register. The sequencer ends at once on an error or a
// zero mantissa, sets overflow for a denominator beyond eighteen digits, applies
// a positive power of ten as repeated multiplies by ten (saturating the
// numerator once a further multiply would pass its limit), and for a fraction
// removes factors of two and then of five from the denominator, stopping early
// when the numerator runs out of them. A result still waiting in the output
// register holds back the write until it is taken. The datapath divides by five
// in shift-add steps, one 64-bit add per cycle.
module decimal_literal_to_rational (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dltr_pkg::CharW-1:0]  req_char_code,
   input  logic                        req_last_char,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dltr_pkg::NumW-1:0]   rsp_numerator,
   output logic [dltr_pkg::DenW-1:0]   rsp_denominator,
   output logic                        rsp_is_whole,
   output logic [1:0]                  rsp_status
);

   logic                         accept;
   logic                         start;
   logic                         busy;
   logic                         out_busy;
   logic                         fire;
   dltr_pkg::lit_type            lit;
   dltr_pkg::dp_op_type          op;
   dltr_pkg::flags_type          flags;
   logic [dltr_pkg::NumW-1:0]    res_numerator;
   logic [dltr_pkg::DenW-1:0]    res_denominator;
   logic                         res_is_whole;
   dltr_pkg::status_type         res_status;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dltr_pkg::NumW-1:0]    rsp_num_ff;
   logic [dltr_pkg::DenW-1:0]    rsp_den_ff;
   logic                         rsp_whole_ff;
   logic [1:0]                   rsp_status_ff;

   // Input handshake: characters flow while the sequencer is idle
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign start     = accept && req_last_char;

   dltr_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .last_char (req_last_char),
      .lit       (lit)
   );

   dltr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_busy (out_busy),
      .flags    (flags),
      .op       (op),
      .busy     (busy)
   );

   dltr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .lit             (lit),
      .op              (op),
      .flags           (flags),
      .res_numerator   (res_numerator),
      .res_denominator (res_denominator),
      .res_is_whole    (res_is_whole),
      .res_status      (res_status)
   );

   // Output register: written when the emit step finds it free
   assign out_busy     = rsp_valid_ff && !rsp_ready;
   assign fire         = (op == dltr_pkg::OpEmit) && !out_busy;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_num_ff    <= res_numerator;
         rsp_den_ff    <= res_denominator;
         rsp_whole_ff  <= res_is_whole;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_numerator   = rsp_num_ff;
   assign rsp_denominator = rsp_den_ff;
   assign rsp_is_whole    = rsp_whole_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== sv/dltr_lexer.sv =====
// Character intake: one character per cycle while accept is high into mantissa, fraction count and exponent
module dltr_lexer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [dltr_pkg::CharW-1:0]   char_code,
   input  logic                         last_char,
   output dltr_pkg::lit_type            lit
);

   typedef enum logic [2:0] {
      PhInt   = 3'd0,
      PhDot   = 3'd1,
      PhFrac  = 3'd2,
      PhExp   = 3'd3,
      PhESign = 3'd4,
      PhEDig  = 3'd5
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [dltr_pkg::NumW-1:0]    mant_ff, mant_in;
   logic [4:0]                   frac_ff, frac_in;
   logic [7:0]                   exp_ff, exp_in;
   logic                         neg_ff, neg_in;
   dltr_pkg::status_type         err_ff, err_in;

   logic                         is_digit;
   logic                         is_e;
   logic [3:0]                   digit;
   logic [66:0]                  mant_wide;
   logic                         mant_ovf;
   logic [11:0]                  exp_wide;
   logic signed [9:0]            exp_signed;

   assign is_digit = (char_code >= dltr_pkg::CharZero) && (char_code <= dltr_pkg::CharNine);
   assign is_e     = (char_code == dltr_pkg::CharLowE) || (char_code == dltr_pkg::CharUpE);
   assign digit    = is_digit ? 4'(char_code - dltr_pkg::CharZero) : 4'd0;

   // mantissa * 10 + digit, with the overflow test against the 63-bit limit
   assign mant_wide = ({4'b0, mant_ff} << 3) + ({4'b0, mant_ff} << 1) + 67'(digit);
   assign mant_ovf  = mant_wide > 67'(dltr_pkg::NumMax);
   assign exp_wide  = ({4'b0, exp_ff} << 3) + ({4'b0, exp_ff} << 1) + 12'(digit);

   // Next state for one character, then the end-of-literal checks
   always_comb begin
      phase_in = phase_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      exp_in   = exp_ff;
      neg_in   = neg_ff;
      err_in   = err_ff;
      if (err_ff == dltr_pkg::StOk) begin
         unique case (phase_ff) inside
            PhInt: begin
               if (is_digit) begin
                  if (mant_ovf) err_in = dltr_pkg::StOverflow;
                  else          mant_in = mant_wide[dltr_pkg::NumW-1:0];
               end else if (char_code == dltr_pkg::CharDot) begin
                  phase_in = PhDot;
               end else if (is_e) begin
                  phase_in = PhExp;
               end else begin
                  err_in = dltr_pkg::StBadChar;
               end
            end
            PhDot, PhFrac: begin
               if (is_digit) begin
                  phase_in = PhFrac;
                  if (frac_ff >= 5'(dltr_pkg::MaxDecimalDigits)) begin
                     err_in = dltr_pkg::StOverflow;
                  end else begin
                     frac_in = frac_ff + 5'd1;
                     if (mant_ovf) err_in = dltr_pkg::StOverflow;
                     else          mant_in = mant_wide[dltr_pkg::NumW-1:0];
                  end
               end else if (is_e && phase_ff == PhFrac) begin
                  phase_in = PhExp;
               end else begin
                  err_in = dltr_pkg::StBadChar;
               end
            end
            PhExp, PhESign, PhEDig: begin
               if (is_digit) begin
                  phase_in = PhEDig;
                  exp_in   = (exp_wide > 12'd255) ? 8'd255 : exp_wide[7:0];
               end else if (phase_ff == PhExp &&
                            (char_code == dltr_pkg::CharPlus ||
                             char_code == dltr_pkg::CharMinus)) begin
                  phase_in = PhESign;
                  neg_in   = (char_code == dltr_pkg::CharMinus);
               end else if (phase_ff == PhEDig) begin
                  err_in = dltr_pkg::StBadChar;
               end else begin
                  err_in = dltr_pkg::StNoExpDigit;
               end
            end
            default: err_in = dltr_pkg::StBadChar;
         endcase
      end
      // a literal may not end on a bare '.' or before its exponent digits
      if (last_char && err_in == dltr_pkg::StOk) begin
         if (phase_in == PhDot)                              err_in = dltr_pkg::StBadChar;
         else if (phase_in == PhExp || phase_in == PhESign)  err_in = dltr_pkg::StNoExpDigit;
      end
   end

   // net power of ten: signed exponent less fraction digits
   assign exp_signed   = neg_in ? -$signed({2'b0, exp_in}) : $signed({2'b0, exp_in});
   assign lit.mantissa = mant_in;
   assign lit.net      = exp_signed - $signed({5'b0, frac_in});
   assign lit.status   = err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhInt;
         mant_ff  <= '0;
         frac_ff  <= '0;
         exp_ff   <= '0;
         neg_ff   <= 1'b0;
         err_ff   <= dltr_pkg::StOk;
      end else if (accept) begin
         if (last_char) begin
            phase_ff <= PhInt;
            mant_ff  <= '0;
            frac_ff  <= '0;
            exp_ff   <= '0;
            neg_ff   <= 1'b0;
            err_ff   <= dltr_pkg::StOk;
         end else begin
            phase_ff <= phase_in;
            mant_ff  <= mant_in;
            frac_ff  <= frac_in;
            exp_ff   <= exp_in;
            neg_ff   <= neg_in;
            err_ff   <= err_in;
         end
      end
   end

endmodule

// ===== sv/dltr_seq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps
module dltr_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_busy,
   input  dltr_pkg::flags_type   flags,
   output dltr_pkg::dp_op_type   op,
   output logic                  busy
);

   dltr_pkg::upc_type    upc_ff, upc_in;
   logic                 busy_ff, busy_in;
   dltr_pkg::uword_type  word;
   logic                 taken;

   assign word = dltr_pkg::ucode(upc_ff);

   // Jump condition select
   always_comb begin
      taken = 1'b0;
      unique case (word.cond)
         dltr_pkg::CondNone:     taken = 1'b0;
         dltr_pkg::CondAlways:   taken = 1'b1;
         dltr_pkg::CondErr:      taken = flags.err;
         dltr_pkg::CondZero:     taken = flags.zero;
         dltr_pkg::CondNetPos:   taken = flags.net_pos;
         dltr_pkg::CondSmallNeg: taken = flags.small_neg;
         dltr_pkg::CondTwoStop:  taken = flags.two_stop;
         dltr_pkg::CondK5Zero:   taken = flags.k5_zero;
         dltr_pkg::CondNotDiv5:  taken = flags.not_div5;
         dltr_pkg::CondCntZero:  taken = flags.cnt_zero;
         dltr_pkg::CondNumBig:   taken = flags.num_big;
         dltr_pkg::CondOutBusy:  taken = out_busy;
         default:                taken = 1'b0;
      endcase
   end

   // Step counter
   always_comb begin
      upc_in  = upc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            upc_in  = '0;
         end
      end else if (taken) begin
         upc_in = word.target;
      end else if (word.fin) begin
         busy_in = 1'b0;
         upc_in  = '0;
      end else begin
         upc_in = upc_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         busy_ff <= busy_in;
      end
   end

   assign op   = busy_ff ? word.op : dltr_pkg::OpNop;
   assign busy = busy_ff;

endmodule

// ===== sv/dltr_dp.sv =====
// Reduction datapath: numerator, product accumulator, counters and result forming
module dltr_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  dltr_pkg::lit_type           lit,
   input  dltr_pkg::dp_op_type         op,
   output dltr_pkg::flags_type         flags,
   output logic [dltr_pkg::NumW-1:0]   res_numerator,
   output logic [dltr_pkg::DenW-1:0]   res_denominator,
   output logic                        res_is_whole,
   output dltr_pkg::status_type        res_status
);

   logic [63:0]           num_ff, num_in;
   logic [63:0]           acc_ff, acc_in;
   logic [8:0]            cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [4:0]            k2_ff, k2_in;
   logic [4:0]            k5_ff, k5_in;
   dltr_pkg::status_type  err_ff, err_in;

   logic                  has_err;
   logic [8:0]            net_mag;

   assign net_mag = lit.net[9] ? 9'(-lit.net) : 9'(lit.net);

   // Operation decode
   always_comb begin
      num_in = num_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      k2_in  = k2_ff;
      k5_in  = k5_ff;
      err_in = err_ff;
      if (start) begin
         num_in = {1'b0, lit.mantissa};
         cnt_in = net_mag;
         neg_in = lit.net[9];
         k2_in  = '0;
         k5_in  = '0;
         err_in = lit.status;
      end else begin
         unique case (op)
            dltr_pkg::OpNop:     ;
            dltr_pkg::OpSetOvf:  err_in = dltr_pkg::StOverflow;
            dltr_pkg::OpSetK: begin
               k2_in = cnt_ff[4:0];
               k5_in = cnt_ff[4:0];
            end
            dltr_pkg::OpHalve: begin
               num_in = num_ff >> 1;
               k2_in  = k2_ff - 5'd1;
            end
            // exact division by five: multiply by its inverse modulo 2^64
            dltr_pkg::OpMul3:    acc_in = num_ff + (num_ff << 1);
            dltr_pkg::OpAddSh4:  acc_in = acc_ff + (acc_ff << 4);
            dltr_pkg::OpAddSh8:  acc_in = acc_ff + (acc_ff << 8);
            dltr_pkg::OpAddSh16: acc_in = acc_ff + (acc_ff << 16);
            dltr_pkg::OpAddSh32: acc_in = acc_ff + (acc_ff << 32);
            dltr_pkg::OpQuot:    acc_in = (acc_ff << 2) + num_ff;
            dltr_pkg::OpTakeQ: begin
               num_in = acc_ff;
               k5_in  = k5_ff - 5'd1;
            end
            dltr_pkg::OpMul10: begin
               num_in = (num_ff << 3) + (num_ff << 1);
               cnt_in = cnt_ff - 9'd1;
            end
            dltr_pkg::OpSat:     num_in = {1'b0, dltr_pkg::NumMax};
            dltr_pkg::OpEmit:    ;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         neg_ff <= 1'b0;
         k2_ff  <= '0;
         k5_ff  <= '0;
         err_ff <= dltr_pkg::StOk;
      end else begin
         cnt_ff <= cnt_in;
         neg_ff <= neg_in;
         k2_ff  <= k2_in;
         k5_ff  <= k5_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      acc_ff <= acc_in;
   end

   // Status for the jump conditions
   assign has_err         = (err_ff != dltr_pkg::StOk);
   assign flags.err       = has_err;
   assign flags.zero      = (num_ff == '0);
   assign flags.net_pos   = !neg_ff;
   assign flags.small_neg = (cnt_ff <= 9'(dltr_pkg::MaxDecimalDigits));
   assign flags.two_stop  = (k2_ff == '0) || num_ff[0];
   assign flags.k5_zero   = (k5_ff == '0);
   assign flags.not_div5  = (acc_ff > dltr_pkg::Div5Limit);
   assign flags.cnt_zero  = (cnt_ff == '0);
   assign flags.num_big   = (num_ff > dltr_pkg::NumMaxDiv10);

   // Result: denominator is 2^k2 * 5^k5, an error gives 0/1
   assign res_numerator   = has_err ? '0 : num_ff[dltr_pkg::NumW-1:0];
   assign res_denominator = has_err ? dltr_pkg::DenW'(1) :
                            (dltr_pkg::DenW'(dltr_pkg::pow5(k5_ff)) << k2_ff);
   assign res_is_whole    = !has_err && (k2_ff == '0) && (k5_ff == '0);
   assign res_status      = err_ff;

endmodule

// ===== sv/dltr_checker.sv =====
// Port-level checks on the literal converter
module dltr_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_last_char,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [dltr_pkg::NumW-1:0]   rsp_numerator,
   input  logic [dltr_pkg::DenW-1:0]   rsp_denominator,
   input  logic                        rsp_is_whole,
   input  logic [1:0]                  rsp_status
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_numerator) &&
                                  $stable(rsp_denominator) && $stable(rsp_status))
      else $error("result item changed while stalled");

   // an error item is always 0/1 and not whole
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dltr_pkg::StOk |->
         rsp_numerator == '0 && rsp_denominator == dltr_pkg::DenW'(1) && !rsp_is_whole)
      else $error("error item with non-zero fraction");

   // whole mark agrees with the denominator on good items
   a_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dltr_pkg::StOk |->
         rsp_is_whole == (rsp_denominator == dltr_pkg::DenW'(1)))
      else $error("is_whole disagrees with denominator");

   // the final character starts the reduction, so input stalls next cycle
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_char |=> !req_ready)
      else $error("input taken while reduction runs");

endmodule

bind decimal_literal_to_rational dltr_checker u_dltr_checker (.*);
